### hdl/psc_pkg.sv
// psc_pkg: shared types and constants for the pid speed controller
// number formats, register indexes and the bundles passed between pipeline stages
// no dependencies
package psc_pkg;

  // fraction bits of the gain registers
  localparam int GAIN_FRAC_BITS = 16;

  localparam int VAL_W  = 16;          // q8.8 values
  localparam int GAIN_W = 32;          // q16.16 gains
  localparam int ERR_W  = VAL_W + 1;   // signed error
  localparam int DIFF_W = ERR_W + 1;   // signed error difference
  localparam int SUM_W  = 32;          // signed error sum
  localparam int PKP_W  = GAIN_W + 1 + ERR_W;
  localparam int PKI_W  = GAIN_W + 1 + SUM_W;
  localparam int PKD_W  = GAIN_W + 1 + DIFF_W;
  localparam int TOT_W  = PKI_W + 1;
  localparam int CFG_AW = 3;

  localparam logic REQ_GOAL  = 1'b0;
  localparam logic REQ_SPEED = 1'b1;

  typedef enum logic [CFG_AW-1:0] {
    REG_KP         = 3'd0,
    REG_KI_DT      = 3'd1,
    REG_KD_OVER_DT = 3'd2,
    REG_OUT_MIN    = 3'd3,
    REG_OUT_MAX    = 3'd4
  } psc_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki_dt;
    logic [GAIN_W-1:0] kd_over_dt;
    logic [VAL_W-1:0]  out_min;
    logic [VAL_W-1:0]  out_max;
  } psc_cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  sum;
  } psc_err_t;

  typedef struct packed {
    logic signed [PKP_W-1:0] p_kp;
    logic signed [PKI_W-1:0] p_ki;
    logic signed [PKD_W-1:0] p_kd;
  } psc_prod_t;

endpackage

### hdl/psc_err_stage.sv
// psc_err_stage: first pipeline stage, holds setpoint and controller history
// forms error, saturated error sum and error difference; uses psc_pkg
module psc_err_stage import psc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_req,
  input  logic [VAL_W-1:0] in_value,
  output logic             in_ready,
  input  logic             nxt_ready,
  output logic             err_valid,
  output psc_err_t         err_data
);

  logic [VAL_W-1:0]        goal_r, goal_nxt;
  logic [VAL_W-1:0]        last_spd_r, last_spd_nxt;
  logic signed [ERR_W-1:0] prev_err_r, prev_err_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    valid_r, valid_nxt;
  psc_err_t                data_r, data_nxt;

  logic                    accept;
  logic [VAL_W-1:0]        speed;
  logic signed [ERR_W-1:0] err;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;

  assign in_ready = !valid_r || nxt_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // a zero reading falls back to the last nonzero one
    speed    = (in_value == '0) ? last_spd_r : in_value;
    err      = $signed({1'b0, goal_r}) - $signed({1'b0, speed});
    sum_wide = {sum_r[SUM_W-1], sum_r} + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end

    goal_nxt     = goal_r;
    last_spd_nxt = last_spd_r;
    prev_err_nxt = prev_err_r;
    sum_nxt      = sum_r;
    valid_nxt    = in_ready ? 1'b0 : valid_r;
    data_nxt     = data_r;
    data_nxt.err = err;
    data_nxt.sum = sum_sat;
    data_nxt.diff = {err[ERR_W-1], err} - {prev_err_r[ERR_W-1], prev_err_r};

    if (accept) begin
      if (in_req == REQ_GOAL) begin
        goal_nxt = in_value;
      end else begin
        if (in_value != '0) begin
          last_spd_nxt = in_value;
        end
        prev_err_nxt = err;
        sum_nxt      = sum_sat;
        valid_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r     <= '0;
      last_spd_r <= '0;
      prev_err_r <= '0;
      sum_r      <= '0;
      valid_r    <= 1'b0;
    end else begin
      goal_r     <= goal_nxt;
      last_spd_r <= last_spd_nxt;
      prev_err_r <= prev_err_nxt;
      sum_r      <= sum_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_req == REQ_SPEED) begin
      data_r <= data_nxt;
    end
  end

  assign err_valid = valid_r;
  assign err_data  = data_r;

endmodule

### hdl/psc_mul_stage.sv
// psc_mul_stage: second pipeline stage, the three gain products in parallel
// unsigned gains times signed values, registered; uses psc_pkg
module psc_mul_stage import psc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  psc_cfg_t  cfg,
  input  logic      err_valid,
  input  psc_err_t  err_data,
  output logic      err_ready,
  input  logic      nxt_ready,
  output logic      prod_valid,
  output psc_prod_t prod_data
);

  logic      valid_r;
  psc_prod_t data_r, data_nxt;

  assign err_ready = !valid_r || nxt_ready;

  always_comb begin
    data_nxt.p_kp = $signed({1'b0, cfg.kp}) * err_data.err;
    data_nxt.p_ki = $signed({1'b0, cfg.ki_dt}) * err_data.sum;
    data_nxt.p_kd = $signed({1'b0, cfg.kd_over_dt}) * err_data.diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (err_ready) begin
      valid_r <= err_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (err_ready && err_valid) begin
      data_r <= data_nxt;
    end
  end

  assign prod_valid = valid_r;
  assign prod_data  = data_r;

endmodule

### hdl/psc_clamp_stage.sv
// psc_clamp_stage: last pipeline stage, sums the products and clamps the throttle
// floor back to q8.8, sign check before upper clamp; holds the output register; uses psc_pkg
module psc_clamp_stage import psc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  psc_cfg_t         cfg,
  input  logic             prod_valid,
  input  psc_prod_t        prod_data,
  output logic             prod_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [VAL_W-1:0] out_throttle
);

  localparam int QW = TOT_W - GAIN_FRAC_BITS;

  logic                    valid_r;
  logic [VAL_W-1:0]        thr_r, thr_nxt;
  logic signed [TOT_W-1:0] total;
  logic [QW-1:0]           q;

  assign prod_ready = !valid_r || out_ready;

  always_comb begin
    total = TOT_W'(prod_data.p_kp) + TOT_W'(prod_data.p_ki) + TOT_W'(prod_data.p_kd);
    q     = total[TOT_W-1:GAIN_FRAC_BITS];
    // a negative total floors below any lower clamp
    priority if (total[TOT_W-1]) begin
      thr_nxt = cfg.out_min;
    end else if (q > QW'(cfg.out_max)) begin
      thr_nxt = cfg.out_max;
    end else if (q < QW'(cfg.out_min)) begin
      thr_nxt = cfg.out_min;
    end else begin
      thr_nxt = q[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (prod_ready) begin
      valid_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      thr_r <= thr_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_throttle = thr_r;

endmodule

### hdl/pid_speed_controller_core.sv
// pid_speed_controller_core: top level of the positional pid throttle controller
// holds the configuration registers and chains the error, multiply and clamp stages
// depends on psc_pkg, psc_err_stage, psc_mul_stage, psc_clamp_stage
//
// Takes one item per clock while out_tready is high and gives a throttle for each speed
// sample accepted; goal items only load the setpoint and give no result. The three
// stages (error and sum update, the three gain products, sum and clamp) each
// have their own register and valid bit. While a finished throttle waits for
// out_tready the input side takes at most two more speed samples, one for each
// of the first two stages, and then holds in_tready low until the throttle is
// taken. The controller history is updated within the first stage, which is what
// allows one sample per clock. Gains and clamp limits are written through the cfg
// port only while the block is idle; the user must keep to this, the block does not enforce it.
module pid_speed_controller_core import psc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [15:0] value
  input  logic [0:0]        in_tuser,   // [0] req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [15:0] throttle
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [31:0]       cfg_wdata
);

  psc_cfg_t  cfg_r;
  logic      err_valid, err_ready;
  psc_err_t  err_data;
  logic      prod_valid, prod_ready;
  psc_prod_t prod_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp         <= 32'd65536;
      cfg_r.ki_dt      <= 32'd164;
      cfg_r.kd_over_dt <= 32'd131072;
      cfg_r.out_min    <= 16'd0;
      cfg_r.out_max    <= 16'd65280;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KP:         cfg_r.kp         <= cfg_wdata;
        REG_KI_DT:      cfg_r.ki_dt      <= cfg_wdata;
        REG_KD_OVER_DT: cfg_r.kd_over_dt <= cfg_wdata;
        REG_OUT_MIN:    cfg_r.out_min    <= cfg_wdata[VAL_W-1:0];
        REG_OUT_MAX:    cfg_r.out_max    <= cfg_wdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  psc_err_stage u_err (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_req    (in_tuser[0]),
    .in_value  (in_tdata),
    .in_ready  (in_tready),
    .nxt_ready (err_ready),
    .err_valid (err_valid),
    .err_data  (err_data)
  );

  psc_mul_stage u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .err_valid  (err_valid),
    .err_data   (err_data),
    .err_ready  (err_ready),
    .nxt_ready  (prod_ready),
    .prod_valid (prod_valid),
    .prod_data  (prod_data)
  );

  psc_clamp_stage u_clamp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .prod_valid   (prod_valid),
    .prod_data    (prod_data),
    .prod_ready   (prod_ready),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_throttle (out_tdata)
  );

endmodule

### hdl/psc_checker.sv
// psc_checker: port-level checks for pid_speed_controller_core
// bound to the top level; depends on psc_pkg
module psc_checker import psc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [0:0]        in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [15:0]       out_tdata
);

  // a stalled throttle holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("throttle changed while stalled");

  // reset empties the pipeline
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // with the output register empty nothing upstream can block
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a new throttle comes from an accepted speed sample
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tuser[0] == REQ_SPEED, 3))
    else $error("throttle without matching speed transaction");

endmodule

bind pid_speed_controller_core psc_checker u_psc_checker (.*);
